FILE: rtl/core/urde_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urde_pkg
// Types, codes and CRC helper shared by the UART register datagram engine.
// ----------------------------------------------------------------------------
package urde_pkg;

  localparam logic [7:0] SyncByte  = 8'h05;
  localparam logic [7:0] CrcPoly   = 8'h07;
  localparam logic [3:0] RxLastPos = 4'd11;
  localparam logic [3:0] RxCrcPos  = 4'd4;
  localparam logic [3:0] RxValPos  = 4'd7;
  localparam logic [3:0] WrLen     = 4'd8;
  localparam logic [3:0] RdLen     = 4'd4;
  localparam logic [15:0] CntMax   = 16'hFFFF;
  localparam logic [15:0] TimeoutReset = 16'd100;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_READ  = 2'd1,
    CMD_RX    = 2'd2,
    CMD_TICK  = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_TIMEOUT = 2'd1,
    ST_CRC     = 2'd2
  } status_e;

  typedef enum logic {
    CFG_NODE_ADDR = 1'b0,
    CFG_TIMEOUT   = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]  command;
    logic [6:0]  reg_addr;
    logic [31:0] write_data;
    logic [7:0]  rx_byte;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [7:0]  tx_byte;
    logic        last;
    logic        reply_valid;
    logic [1:0]  reply_status;
    logic [31:0] read_value;
    logic [15:0] timeout_count;
    logic [15:0] crc_error_count;
  } out_item_t;

  // one item's worth of results: a datagram or a single reply
  typedef struct packed {
    logic [7:0][7:0] bytes;
    logic [3:0]      len;
    logic            reply;
    logic [1:0]      status;
    logic [31:0]     value;
    logic [15:0]     tcount;
    logic [15:0]     ecount;
  } frame_t;

  // CRC-8, data fed LSB first
  function automatic logic [7:0] crc_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc;
    for (int j = 0; j < 8; j++) begin
      if (c[7] ^ b[j]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/urde_link.sv
`default_nettype none
// ----------------------------------------------------------------------------
// urde_link
// Link state and datagram build: turns one command into a frame descriptor.
// ----------------------------------------------------------------------------
module urde_link (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            go_i,
  input  wire urde_pkg::in_item_t item_i,
  input  wire logic [7:0]      node_addr_i,
  input  wire logic [15:0]     timeout_ticks_i,
  output urde_pkg::frame_t     frame_o
);
  import urde_pkg::*;

  logic        pend_q, pend_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [31:0] val_q, val_d;
  logic [15:0] wait_q, wait_d;
  logic [15:0] tcnt_q, tcnt_d;
  logic [15:0] ecnt_q, ecnt_d;

  logic [7:0]  crc_w;
  logic [7:0]  crc_r;
  logic [15:0] wait_inc;

  always_comb begin
    crc_w = 8'h00;
    crc_w = crc_feed(crc_w, SyncByte);
    crc_w = crc_feed(crc_w, node_addr_i);
    crc_w = crc_feed(crc_w, {1'b1, item_i.reg_addr});
    crc_w = crc_feed(crc_w, item_i.write_data[31:24]);
    crc_w = crc_feed(crc_w, item_i.write_data[23:16]);
    crc_w = crc_feed(crc_w, item_i.write_data[15:8]);
    crc_w = crc_feed(crc_w, item_i.write_data[7:0]);
    crc_r = 8'h00;
    crc_r = crc_feed(crc_r, SyncByte);
    crc_r = crc_feed(crc_r, node_addr_i);
    crc_r = crc_feed(crc_r, {1'b0, item_i.reg_addr});
  end

  assign wait_inc = (wait_q != CntMax) ? wait_q + 16'd1 : wait_q;

  always_comb begin
    pend_d = pend_q;
    pos_d  = pos_q;
    crc_d  = crc_q;
    val_d  = val_q;
    wait_d = wait_q;
    tcnt_d = tcnt_q;
    ecnt_d = ecnt_q;
    frame_o = '0;
    unique case (cmd_e'(item_i.command))
      CMD_WRITE: begin
        frame_o.bytes[0] = SyncByte;
        frame_o.bytes[1] = node_addr_i;
        frame_o.bytes[2] = {1'b1, item_i.reg_addr};
        frame_o.bytes[3] = item_i.write_data[31:24];
        frame_o.bytes[4] = item_i.write_data[23:16];
        frame_o.bytes[5] = item_i.write_data[15:8];
        frame_o.bytes[6] = item_i.write_data[7:0];
        frame_o.bytes[7] = crc_w;
        frame_o.len      = WrLen;
      end
      CMD_READ: begin
        frame_o.bytes[0] = SyncByte;
        frame_o.bytes[1] = node_addr_i;
        frame_o.bytes[2] = {1'b0, item_i.reg_addr};
        frame_o.bytes[3] = crc_r;
        frame_o.len      = RdLen;
        pend_d = 1'b1;
        pos_d  = '0;
        crc_d  = '0;
        val_d  = '0;
        wait_d = '0;
      end
      CMD_RX: begin
        if (pend_q) begin
          if (pos_q >= RxLastPos) begin
            pend_d = 1'b0;
            pos_d  = '0;
            frame_o.len   = 4'd1;
            frame_o.reply = 1'b1;
            if (crc_q == item_i.rx_byte) begin
              frame_o.status = ST_OK;
              frame_o.value  = val_q;
            end else begin
              frame_o.status = ST_CRC;
              if (ecnt_q != CntMax) begin
                ecnt_d = ecnt_q + 16'd1;
              end
            end
          end else begin
            if (pos_q >= RxCrcPos) begin
              crc_d = crc_feed(crc_q, item_i.rx_byte);
            end
            if (pos_q >= RxValPos) begin
              val_d = {val_q[23:0], item_i.rx_byte};
            end
            pos_d = pos_q + 4'd1;
          end
        end
      end
      CMD_TICK: begin
        if (pend_q) begin
          wait_d = wait_inc;
          if (wait_inc >= timeout_ticks_i) begin
            pend_d = 1'b0;
            pos_d  = '0;
            frame_o.len    = 4'd1;
            frame_o.reply  = 1'b1;
            frame_o.status = ST_TIMEOUT;
            if (tcnt_q != CntMax) begin
              tcnt_d = tcnt_q + 16'd1;
            end
          end
        end
      end
      default: ;
    endcase
    frame_o.tcount = tcnt_d;
    frame_o.ecount = ecnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
      pos_q  <= '0;
      crc_q  <= '0;
      val_q  <= '0;
      wait_q <= '0;
      tcnt_q <= '0;
      ecnt_q <= '0;
    end else if (go_i) begin
      pend_q <= pend_d;
      pos_q  <= pos_d;
      crc_q  <= crc_d;
      val_q  <= val_d;
      wait_q <= wait_d;
      tcnt_q <= tcnt_d;
      ecnt_q <= ecnt_d;
    end
  end

  a_pos_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !pend_q |-> pos_q == 4'd0)
    else $error("rx position nonzero without pending read");

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_q |-> pos_q <= RxLastPos)
    else $error("rx position past reply end");

  a_reply_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go_i && frame_o.reply |-> frame_o.len == 4'd1)
    else $error("reply frame not single");

endmodule
`default_nettype wire

FILE: rtl/core/uart_register_datagram_engine.sv
`default_nettype none
// ----------------------------------------------------------------------------
// uart_register_datagram_engine
// Host side of a single-wire UART register link with CRC-8 datagrams.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+-------------------------------------
//  in      | in  | in_valid_i/stall_o | in_item_i  (command, reg, data, rx)
//  out     | out | out_valid_o/stall_i| out_item_o (tx byte or read reply)
//  cfg     | in  | cfg_valid_i/ready_o| cfg_index_i, cfg_data_i
//
// An item is registered on accept and processed into a frame buffer when free;
// one transaction per cycle leaves the buffer unless stalled. A write sends 8
// bytes, a read 4, a completed reply 1, all others none; input runs at one item
// per cycle otherwise. Reset clears all link state and counters. Output stall
// backs up into the frame buffer, then the input register.
// ----------------------------------------------------------------------------
module uart_register_datagram_engine (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output      logic                in_stall_o,
  input  wire urde_pkg::in_item_t  in_item_i,
  output      logic                out_valid_o,
  input  wire logic                out_stall_i,
  output      urde_pkg::out_item_t out_item_o,
  input  wire logic                cfg_valid_i,
  output      logic                cfg_ready_o,
  input  wire logic                cfg_index_i,
  input  wire logic [15:0]         cfg_data_i
);
  import urde_pkg::*;

  logic        in_valid_q;
  in_item_t    in_item_q;
  logic [7:0]  node_q;
  logic [15:0] tmo_q;
  frame_t      frame;
  frame_t      buf_q;
  logic        busy_q;
  logic [2:0]  ptr_q;
  logic        out_last;
  logic        out_take;
  logic        advance;
  logic        go;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_q <= '0;
      tmo_q  <= TimeoutReset;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_NODE_ADDR: node_q <= cfg_data_i[7:0];
        CFG_TIMEOUT:   tmo_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign out_last = buf_q.reply || ({1'b0, ptr_q} == buf_q.len - 4'd1);
  assign out_take = busy_q && !out_stall_i;
  assign advance  = !busy_q || (out_take && out_last);
  assign go       = in_valid_q && advance;
  assign in_stall_o = in_valid_q && !advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_item_q <= in_item_i;
    end
  end

  urde_link u_link (
    .clk_i,
    .rst_ni,
    .go_i            (go),
    .item_i          (in_item_q),
    .node_addr_i     (node_q),
    .timeout_ticks_i (tmo_q),
    .frame_o         (frame)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      ptr_q  <= '0;
    end else if (go) begin
      busy_q <= (frame.len != 4'd0);
      ptr_q  <= '0;
    end else if (out_take) begin
      if (out_last) begin
        busy_q <= 1'b0;
      end
      ptr_q <= ptr_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (go) begin
      buf_q <= frame;
    end
  end

  always_comb begin
    out_valid_o = busy_q;
    out_item_o.tx_valid        = !buf_q.reply;
    out_item_o.tx_byte         = buf_q.reply ? 8'h00 : buf_q.bytes[ptr_q];
    out_item_o.last            = out_last;
    out_item_o.reply_valid     = buf_q.reply;
    out_item_o.reply_status    = buf_q.status;
    out_item_o.read_value      = buf_q.value;
    out_item_o.timeout_count   = buf_q.tcount;
    out_item_o.crc_error_count = buf_q.ecount;
  end

  a_ptr_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> {1'b0, ptr_q} < buf_q.len)
    else $error("frame pointer beyond frame length");

  a_frame_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !out_last |=> out_valid_o && !out_item_o.reply_valid)
    else $error("datagram interrupted");

  a_stall_holds_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && busy_q)
    else $error("input stalled without reason");

  a_reply_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && buf_q.reply |-> out_last && !out_item_o.tx_valid)
    else $error("reply result not single");

endmodule
`default_nettype wire
